FILE: src/dtmf_pkg.sv
package dtmf_pkg;

  localparam int STEP_W   = 11;
  localparam int CNT_W    = 16;
  localparam int VOL_W    = 14;
  localparam int LEN_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int SYM_W    = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int ACC_W    = 31;

  // Depth of the sine pipeline, in stages.
  localparam int SINE_LAT = 9;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_VOLUME      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_LENGTH = 8'd1;

  localparam logic [VOL_W-1:0] VOLUME_RESET      = 14'd1000;
  localparam logic [LEN_W-1:0] TONE_LENGTH_RESET = 16'd8000;

  localparam logic [STEP_W-1:0] ROW_1 = 11'd697;
  localparam logic [STEP_W-1:0] ROW_2 = 11'd770;
  localparam logic [STEP_W-1:0] ROW_3 = 11'd852;
  localparam logic [STEP_W-1:0] ROW_4 = 11'd941;
  localparam logic [STEP_W-1:0] COL_1 = 11'd1209;
  localparam logic [STEP_W-1:0] COL_2 = 11'd1336;
  localparam logic [STEP_W-1:0] COL_3 = 11'd1477;
  localparam logic [STEP_W-1:0] COL_4 = 11'd1633;

  // Odd polynomial coefficients for sin(pi/2 * u), unsigned Q30.
  localparam logic [ACC_W-1:0] K1 = 31'd1686629713;
  localparam logic [ACC_W-1:0] K3 = 31'd693598670;
  localparam logic [ACC_W-1:0] K5 = 31'd85569306;
  localparam logic [ACC_W-1:0] K7 = 31'd5026991;
  localparam logic [ACC_W-1:0] K9 = 31'd172271;
  localparam logic [ACC_W-1:0] Q30_ONE  = 31'd1073741824;
  localparam logic [ACC_W-1:0] Q30_HALF = 31'd536870912;

  typedef struct packed {
    logic              valid;
    logic [STEP_W-1:0] row;
    logic [STEP_W-1:0] col;
  } tone_dec_t;

  typedef struct packed {
    logic on;
    logic last;
    logic bad;
  } item_flags_t;

  localparam int FLAGS_W = $bits(item_flags_t);

  function automatic tone_dec_t decode_symbol(input logic [SYM_W-1:0] sym);
    tone_dec_t d;
    d.valid = 1'b1;
    d.row   = '0;
    d.col   = '0;
    case (sym)
      "1": begin d.row = ROW_1; d.col = COL_1; end
      "2": begin d.row = ROW_1; d.col = COL_2; end
      "3": begin d.row = ROW_1; d.col = COL_3; end
      "A": begin d.row = ROW_1; d.col = COL_4; end
      "4": begin d.row = ROW_2; d.col = COL_1; end
      "5": begin d.row = ROW_2; d.col = COL_2; end
      "6": begin d.row = ROW_2; d.col = COL_3; end
      "B": begin d.row = ROW_2; d.col = COL_4; end
      "7": begin d.row = ROW_3; d.col = COL_1; end
      "8": begin d.row = ROW_3; d.col = COL_2; end
      "9": begin d.row = ROW_3; d.col = COL_3; end
      "C": begin d.row = ROW_3; d.col = COL_4; end
      "*": begin d.row = ROW_4; d.col = COL_1; end
      "0": begin d.row = ROW_4; d.col = COL_2; end
      "#": begin d.row = ROW_4; d.col = COL_3; end
      "D": begin d.row = ROW_4; d.col = COL_4; end
      " ": begin d.row = '0; d.col = '0; end
      default: begin
        d.valid = 1'b0;
      end
    endcase
    return d;
  endfunction

endpackage

FILE: src/dtmf_channels.sv
interface dtmf_req_if import dtmf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, output func, output symbol, input ready);
  modport sink   (input valid, input func, input symbol, output ready);
endinterface

interface dtmf_smp_if import dtmf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       bad_symbol;
  logic                       active;

  modport source (output valid, output sample, output last, output bad_symbol,
                  output active, input ready);
  modport sink   (input valid, input sample, input last, input bad_symbol,
                  input active, output ready);
endinterface

interface dtmf_cfg_if import dtmf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/dtmf_tone_generator_core.sv
// Each accepted request passes through the nine-stage sine pipeline
// (phase-to-angle, fold, Horner steps, volume scaling) and then the
// output register before its sample appears on the output.
// Throughput: one request per cycle while the queue is not full; a 4-entry
// queue sits between the tone-state front end and the sample pipeline.
// Reset (synchronous, active high) clears tone state and loads the defaults.
module dtmf_tone_generator_core import dtmf_pkg::*; #(
  parameter int SAMPLE_RATE = 8000
) (
  input  logic       clk,
  input  logic       rst,
  dtmf_req_if.sink   tone_in,
  dtmf_cfg_if.sink   cfg,
  dtmf_smp_if.source sample_out
);

  localparam int PHASE_W = $clog2(SAMPLE_RATE);
  localparam int ENTRY_W = 2 * PHASE_W + FLAGS_W;
  localparam int QUEUE_DEPTH = 4;

  logic                push, pop, full, empty;
  logic [PHASE_W-1:0]  wr_row_phase, wr_col_phase;
  logic [PHASE_W-1:0]  rd_row_phase, rd_col_phase;
  item_flags_t         wr_flags, rd_flags;
  logic [VOL_W-1:0]    volume;
  logic [ENTRY_W-1:0]  wr_entry, rd_entry;

  assign wr_entry = {wr_row_phase, wr_col_phase, wr_flags};
  assign {rd_row_phase, rd_col_phase, rd_flags} = rd_entry;

  dtmf_front #(.SAMPLE_RATE(SAMPLE_RATE)) u_front (
    .clk             (clk),
    .rst             (rst),
    .tone_in         (tone_in),
    .cfg             (cfg),
    .full            (full),
    .push            (push),
    .entry_row_phase (wr_row_phase),
    .entry_col_phase (wr_col_phase),
    .entry_flags     (wr_flags),
    .volume          (volume)
  );

  dtmf_fifo #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wr_entry),
    .pop   (pop),
    .rdata (rd_entry),
    .full  (full),
    .empty (empty)
  );

  dtmf_back #(.SAMPLE_RATE(SAMPLE_RATE)) u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .row_phase  (rd_row_phase),
    .col_phase  (rd_col_phase),
    .flags      (rd_flags),
    .volume     (volume),
    .pop        (pop),
    .sample_out (sample_out)
  );

endmodule

FILE: src/dtmf_front.sv
module dtmf_front import dtmf_pkg::*; #(
  parameter int SAMPLE_RATE = 8000
) (
  input  logic                              clk,
  input  logic                              rst,
  dtmf_req_if.sink                          tone_in,
  dtmf_cfg_if.sink                          cfg,
  input  logic                              full,
  output logic                              push,
  output logic [$clog2(SAMPLE_RATE)-1:0]    entry_row_phase,
  output logic [$clog2(SAMPLE_RATE)-1:0]    entry_col_phase,
  output item_flags_t                       entry_flags,
  output logic [VOL_W-1:0]                  volume
);

  localparam int PHASE_W = $clog2(SAMPLE_RATE);
  localparam logic [PHASE_W:0] RATE = (PHASE_W+1)'(SAMPLE_RATE);

  logic [PHASE_W-1:0] row_phase, row_phase_next;
  logic [PHASE_W-1:0] col_phase, col_phase_next;
  logic [STEP_W-1:0]  row_step, row_step_next;
  logic [STEP_W-1:0]  col_step, col_step_next;
  logic [CNT_W-1:0]   sample_count, sample_count_next;
  logic               tone_active, tone_active_next;
  logic [LEN_W-1:0]   tone_length;

  logic               accept;
  tone_dec_t          dec;
  logic [LEN_W-1:0]   len_eff;
  logic [PHASE_W-1:0] rp_eff, cp_eff;
  logic [CNT_W-1:0]   cnt_eff, cnt_inc;
  logic               act_eff, bad, is_last;
  logic [PHASE_W:0]   row_sum, col_sum;

  assign tone_in.ready = !full;
  assign accept        = tone_in.valid && tone_in.ready;
  assign push          = accept;
  assign cfg.ready     = 1'b1;

  always_comb begin
    dec      = decode_symbol(tone_in.symbol);
    len_eff  = (tone_length == '0) ? LEN_W'(1) : tone_length;
    rp_eff   = row_phase;
    cp_eff   = col_phase;
    row_step_next = row_step;
    col_step_next = col_step;
    cnt_eff  = sample_count;
    act_eff  = tone_active;
    bad      = 1'b0;
    if (tone_in.func == FUNC_START) begin
      cnt_eff = '0;
      if (dec.valid) begin
        row_step_next = dec.row;
        col_step_next = dec.col;
        rp_eff  = '0;
        cp_eff  = '0;
        act_eff = 1'b1;
      end else begin
        row_step_next = '0;
        col_step_next = '0;
        act_eff = 1'b0;
        bad     = 1'b1;
      end
    end

    // Steps stay below the rate, so one conditional subtract wraps the phase.
    row_sum = {1'b0, rp_eff} + (PHASE_W+1)'(row_step_next);
    col_sum = {1'b0, cp_eff} + (PHASE_W+1)'(col_step_next);
    cnt_inc = cnt_eff + CNT_W'(1);
    is_last = (cnt_inc >= len_eff) || (cnt_inc == '0);

    if (act_eff) begin
      row_phase_next    = (row_sum >= RATE) ? PHASE_W'(row_sum - RATE) : PHASE_W'(row_sum);
      col_phase_next    = (col_sum >= RATE) ? PHASE_W'(col_sum - RATE) : PHASE_W'(col_sum);
      sample_count_next = cnt_inc;
      tone_active_next  = !is_last;
    end else begin
      row_phase_next    = rp_eff;
      col_phase_next    = cp_eff;
      sample_count_next = cnt_eff;
      tone_active_next  = 1'b0;
    end

    entry_row_phase  = rp_eff;
    entry_col_phase  = cp_eff;
    entry_flags.on   = act_eff;
    entry_flags.last = act_eff && is_last;
    entry_flags.bad  = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_phase    <= '0;
      col_phase    <= '0;
      row_step     <= '0;
      col_step     <= '0;
      sample_count <= '0;
      tone_active  <= 1'b0;
    end else if (accept) begin
      row_phase    <= row_phase_next;
      col_phase    <= col_phase_next;
      row_step     <= row_step_next;
      col_step     <= col_step_next;
      sample_count <= sample_count_next;
      tone_active  <= tone_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume      <= VOLUME_RESET;
      tone_length <= TONE_LENGTH_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_VOLUME:      volume      <= cfg.data[VOL_W-1:0];
        REG_TONE_LENGTH: tone_length <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/dtmf_fifo.sv
module dtmf_fifo import dtmf_pkg::*; #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/dtmf_sine.sv
module dtmf_sine import dtmf_pkg::*; #(
  parameter int SAMPLE_RATE = 8000
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [$clog2(SAMPLE_RATE)-1:0] phase,
  input  logic [VOL_W-1:0]               volume,
  output logic signed [SAMPLE_W-1:0]     term
);

  localparam int PHASE_W = $clog2(SAMPLE_RATE);
  localparam int NUM_W   = PHASE_W + 16;
  // Rounded-up reciprocal of the rate in Q32: the quotient estimate is
  // then exact or one too high.
  localparam longint unsigned RECIP =
    ((64'd1 << 32) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);
  localparam int REC_W  = $clog2(RECIP + 1);
  localparam int PROD_W = NUM_W + REC_W;
  localparam int ANG_W  = 17;

  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  num1;
  logic [PROD_W-1:0] prod1;
  logic [ANG_W-1:0]  qest;
  logic [33:0]       chk;
  logic [ANG_W-1:0]  ang;
  logic [15:0]       ang2;
  logic [14:0]       x_raw, x_fold;
  logic [29:0]       sq;
  logic [14:0]       x3, x4, x5, x6, x7;
  logic [1:0]        q3, q4, q5, q6, q7, q8;
  logic [ACC_W-1:0]  t2_3, t2_4, t2_5, t2_6;
  logic [ACC_W-1:0]  acc7, acc5, acc3, acc1;
  logic [2*ACC_W-1:0] p4, p5, p6, p7;
  logic [45:0]       sp;
  logic [31:0]       s_full;
  logic [ACC_W-1:0]  s8;
  logic [44:0]       mp;
  logic [14:0]       mag;
  logic signed [SAMPLE_W-1:0] mag_s;

  always_comb begin
    num    = {phase, 16'b0} + NUM_W'(SAMPLE_RATE / 2);
    qest   = ANG_W'(prod1 >> 32);
    chk    = 34'(qest) * 34'(SAMPLE_RATE);
    ang    = (chk > 34'(num1)) ? qest - ANG_W'(1) : qest;
    x_raw  = {1'b0, ang2[13:0]};
    x_fold = ang2[14] ? 15'd16384 - x_raw : x_raw;
    sq     = 30'(x_fold) * 30'(x_fold);
    p4     = (2*ACC_W)'(t2_3) * (2*ACC_W)'(K9);
    p5     = (2*ACC_W)'(t2_4) * (2*ACC_W)'(acc7);
    p6     = (2*ACC_W)'(t2_5) * (2*ACC_W)'(acc5);
    p7     = (2*ACC_W)'(t2_6) * (2*ACC_W)'(acc3);
    sp     = 46'(x7) * 46'(acc1);
    s_full = 32'(sp >> 14);
    mp     = 45'(s8) * 45'(volume) + 45'(Q30_HALF);
    mag    = 15'(mp >> 30);
    mag_s  = $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1  <= num;
      prod1 <= PROD_W'(num) * PROD_W'(RECIP);
      ang2  <= ang[15:0];
      x3    <= x_fold;
      q3    <= ang2[15:14];
      t2_3  <= {sq[28:0], 2'b00};
      acc7  <= K7 - ACC_W'(p4 >> 30);
      x4    <= x3;
      q4    <= q3;
      t2_4  <= t2_3;
      acc5  <= K5 - ACC_W'(p5 >> 30);
      x5    <= x4;
      q5    <= q4;
      t2_5  <= t2_4;
      acc3  <= K3 - ACC_W'(p6 >> 30);
      x6    <= x5;
      q6    <= q5;
      t2_6  <= t2_5;
      acc1  <= K1 - ACC_W'(p7 >> 30);
      x7    <= x6;
      q7    <= q6;
      s8    <= (s_full > 32'(Q30_ONE)) ? Q30_ONE : ACC_W'(s_full);
      q8    <= q7;
      // The lower half of the wave is negated.
      term  <= q8[1] ? -mag_s : mag_s;
    end
  end

endmodule

FILE: src/dtmf_back.sv
module dtmf_back import dtmf_pkg::*; #(
  parameter int SAMPLE_RATE = 8000
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           empty,
  input  logic [$clog2(SAMPLE_RATE)-1:0] row_phase,
  input  logic [$clog2(SAMPLE_RATE)-1:0] col_phase,
  input  item_flags_t                    flags,
  input  logic [VOL_W-1:0]               volume,
  output logic                           pop,
  dtmf_smp_if.source                     sample_out
);

  logic                       en;
  logic                       vld [SINE_LAT];
  item_flags_t                fl  [SINE_LAT];
  logic signed [SAMPLE_W-1:0] row_term, col_term;

  // The whole pipeline advances together; it holds only when the output
  // register is full and not being taken.
  assign en  = !sample_out.valid || sample_out.ready;
  assign pop = en && !empty;

  dtmf_sine #(.SAMPLE_RATE(SAMPLE_RATE)) u_row_sine (
    .clk    (clk),
    .en     (en),
    .phase  (row_phase),
    .volume (volume),
    .term   (row_term)
  );

  dtmf_sine #(.SAMPLE_RATE(SAMPLE_RATE)) u_col_sine (
    .clk    (clk),
    .en     (en),
    .phase  (col_phase),
    .volume (volume),
    .term   (col_term)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SINE_LAT; i++) begin
        vld[i] <= 1'b0;
      end
      sample_out.valid <= 1'b0;
    end else if (en) begin
      vld[0] <= !empty;
      for (int i = 1; i < SINE_LAT; i++) begin
        vld[i] <= vld[i-1];
      end
      sample_out.valid <= vld[SINE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0] <= flags;
      for (int i = 1; i < SINE_LAT; i++) begin
        fl[i] <= fl[i-1];
      end
      sample_out.sample     <= fl[SINE_LAT-1].on ? row_term + col_term : '0;
      sample_out.last       <= fl[SINE_LAT-1].last;
      sample_out.bad_symbol <= fl[SINE_LAT-1].bad;
      sample_out.active     <= fl[SINE_LAT-1].on;
    end
  end

endmodule

FILE: src/dtmf_chk.sv
module dtmf_chk import dtmf_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] sample,
  input logic                       last,
  input logic                       bad_symbol,
  input logic                       active
);

  // A held sample keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(last)
      && $stable(bad_symbol) && $stable(active))
    else $error("output changed while stalled");

  a_bad_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_symbol |-> !active && !last && sample == '0)
    else $error("bad symbol sample not silent");

  a_last_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> active)
    else $error("last flag outside a tone");

  a_idle_silent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !active |-> sample == '0 && !last)
    else $error("idle sample not silent");

endmodule

bind dtmf_tone_generator_core dtmf_chk u_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (sample_out.valid),
  .out_ready  (sample_out.ready),
  .sample     (sample_out.sample),
  .last       (sample_out.last),
  .bad_symbol (sample_out.bad_symbol),
  .active     (sample_out.active)
);
